// ===== hw/rtl/gspe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gspe_pkg: shared types and constants
// Sizes, command codes, result status codes and state encoding for the
// shortest-path engine.
// ----------------------------------------------------------------------------
package gspe_pkg;
	localparam int NODES     = 32;
	localparam int NODE_BITS = 5;
	localparam int COST_BITS = 20;
	localparam int EDGE_BITS = 2 * NODE_BITS;
	localparam int EDGE_DEPTH = NODES * NODES;

	localparam logic [COST_BITS-1:0] COST_MAX = {COST_BITS{1'b1}};

	localparam logic [2:0] CMD_ADD_VERTEX = 3'd0;
	localparam logic [2:0] CMD_DEL_VERTEX = 3'd1;
	localparam logic [2:0] CMD_ADD_EDGE   = 3'd2;
	localparam logic [2:0] CMD_DEL_EDGE   = 3'd3;
	localparam logic [2:0] CMD_QUERY      = 3'd4;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_ABSENT  = 2'd1;
	localparam logic [1:0] ST_UNREACH = 2'd2;

	localparam logic [7:0] TIME_BASE  = 8'd120;
	localparam logic [5:0] TIME_SCALE = 6'd40;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLR,
		S_EDGE_RD,
		S_EDGE_WR,
		S_INIT,
		S_SCAN,
		S_PICK,
		S_RELAX_RD,
		S_RELAX_WR,
		S_OUT
	} state_t;
endpackage

// ===== hw/rtl/graph_shortest_path_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_shortest_path_engine: weighted graph store with shortest-path query
// Holds an undirected graph in an edge memory and answers least-cost queries.
// ----------------------------------------------------------------------------
// Use: input items on s_axis (cmd, vertex indices, weight, time mode) edit
// the graph or start a query. Only a query yields an item on m_axis, carrying
// the least cost and a status (ok, endpoint absent, unreachable).
// After reset the edge memory is cleared in a pass over all 1024 entries,
// one entry a cycle, during which no item is accepted.
// One item is handled at a time. Adding a vertex is done as it is accepted;
// edge commands read the entry in S_EDGE_RD, then update it in S_EDGE_WR;
// removing a vertex sweeps its row and column, alternating between the two.
// A query scans all 32 vertices for the nearest unsettled one, then picks it
// and walks that vertex's edge-memory row, each neighbour in a read and then
// a read-modify-write of the cost memory. The query ends as soon as the
// destination settles or no reached vertex is left unsettled.
// The single-port edge memory sets the query time.
// The result is held in an output register until taken; while m_axis is
// stalled no further item is accepted.
// ----------------------------------------------------------------------------
module graph_shortest_path_engine (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	// cmd[2:0], node_a[7:3], node_b[12:8], weight[20:13], time_mode[21], pad
	input  logic [23:0]              s_axis_tdata,
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	// path_cost[19:0], status[21:20], pad
	output logic [23:0]              m_axis_tdata
);
	import gspe_pkg::*;

	// memories
	logic [8:0]           edge_mem [EDGE_DEPTH];
	logic [COST_BITS-1:0] cost_mem [NODES];
	logic [NODES-1:0]     present_q;
	logic [NODES-1:0]     settled_q;
	logic [NODES-1:0]     reached_q;

	state_t state_q, state_d;

	logic [2:0]           cmd_q;
	logic [NODE_BITS-1:0] a_q, b_q;
	logic [7:0]           w_q;
	logic                 tmode_q;
	logic [EDGE_BITS:0]   clr_cnt_q;
	logic [NODE_BITS:0]   idx_q;
	logic                 phase_q;
	logic [NODE_BITS-1:0] pick_q;
	logic [COST_BITS-1:0] pick_cost_q;
	logic                 found_q;
	logic [COST_BITS-1:0] res_cost_q;
	logic [1:0]           res_status_q;
	logic                 out_valid_q;

	logic [8:0]           edge_rd_s1;
	logic [COST_BITS-1:0] cost_rd_s1;

	// edge and cost memory ports
	logic                  e_we;
	logic [EDGE_BITS-1:0]  e_addr;
	logic [8:0]            e_wdata;
	logic                  c_we;
	logic [NODE_BITS-1:0]  c_waddr, c_raddr;
	logic [COST_BITS-1:0]  c_wdata;

	always_ff @(posedge clk) begin
		if (e_we)
			edge_mem[e_addr] <= e_wdata;
		edge_rd_s1 <= edge_mem[e_addr];
	end

	always_ff @(posedge clk) begin
		if (c_we)
			cost_mem[c_waddr] <= c_wdata;
		cost_rd_s1 <= cost_mem[c_raddr];
	end

	logic s_fire;
	assign s_fire = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE) && !out_valid_q;

	logic [NODE_BITS-1:0] idx_lo;
	assign idx_lo = idx_q[NODE_BITS-1:0];

	// edge cost with time mode and saturating sum
	logic [13:0]          w_cost;
	logic [COST_BITS:0]   sum_full;
	logic [COST_BITS-1:0] new_cost;
	always_comb begin
		if (tmode_q)
			w_cost = 14'(TIME_BASE) + 14'(edge_rd_s1[7:0]) * 14'(TIME_SCALE);
		else
			w_cost = 14'(edge_rd_s1[7:0]);
		sum_full = {1'b0, pick_cost_q} + (COST_BITS+1)'(w_cost);
		new_cost = sum_full[COST_BITS] ? COST_MAX : sum_full[COST_BITS-1:0];
	end

	// neighbour index registered with the read, for use in the cycle after it
	logic [NODE_BITS-1:0] nb_q;

	// next state and memory control
	always_comb begin
		state_d = state_q;
		e_we    = 1'b0;
		e_addr  = {a_q, b_q};
		e_wdata = 9'd0;
		c_we    = 1'b0;
		c_waddr = idx_lo;
		c_raddr = idx_lo;
		c_wdata = '0;
		case (state_q)
			S_CLR: begin
				e_we   = 1'b1;
				e_addr = clr_cnt_q[EDGE_BITS-1:0];
				if (clr_cnt_q == (EDGE_BITS+1)'(EDGE_DEPTH - 1))
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (s_fire) begin
					case (s_axis_tdata[2:0])
						CMD_DEL_VERTEX: state_d = present_q[s_axis_tdata[7:3]] ?
							S_EDGE_WR : S_IDLE;
						CMD_ADD_EDGE,
						CMD_DEL_EDGE:   state_d = S_EDGE_RD;
						CMD_QUERY:      state_d = S_INIT;
						default:        state_d = S_IDLE;
					endcase
				end
			end
			S_EDGE_RD: begin
				e_addr  = {a_q, b_q};
				state_d = S_EDGE_WR;
			end
			S_EDGE_WR: begin
				if (cmd_q == CMD_DEL_VERTEX) begin
					e_we    = 1'b1;
					e_addr  = phase_q ? {idx_lo, a_q} : {a_q, idx_lo};
					if (phase_q && idx_q == (NODE_BITS+1)'(NODES - 1))
						state_d = S_IDLE;
				end else begin
					state_d = S_IDLE;
					if (present_q[a_q] && present_q[b_q] &&
						((cmd_q == CMD_ADD_EDGE) != edge_rd_s1[8])) begin
						e_we    = 1'b1;
						e_wdata = (cmd_q == CMD_ADD_EDGE) ? {1'b1, w_q} : 9'd0;
						e_addr  = phase_q ? {b_q, a_q} : {a_q, b_q};
						state_d = phase_q ? S_IDLE : S_EDGE_WR;
					end else if (phase_q) begin
						e_we    = 1'b1;
						e_wdata = (cmd_q == CMD_ADD_EDGE) ? {1'b1, w_q} : 9'd0;
						e_addr  = {b_q, a_q};
					end
				end
			end
			S_INIT: begin
				if (!present_q[a_q] || !present_q[b_q]) begin
					state_d = S_OUT;
				end else begin
					c_we    = 1'b1;
					c_waddr = a_q;
					c_wdata = '0;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				c_raddr = idx_lo;
				if (idx_q == (NODE_BITS+1)'(NODES))
					state_d = S_PICK;
			end
			S_PICK: begin
				if (!found_q || pick_q == b_q)
					state_d = S_OUT;
				else
					state_d = S_RELAX_RD;
			end
			S_RELAX_RD: begin
				e_addr  = {pick_q, idx_lo};
				c_raddr = idx_lo;
				state_d = S_RELAX_WR;
			end
			S_RELAX_WR: begin
				if (edge_rd_s1[8] && present_q[nb_q] && !settled_q[nb_q] &&
					(!reached_q[nb_q] || new_cost < cost_rd_s1)) begin
					c_we    = 1'b1;
					c_waddr = nb_q;
					c_wdata = new_cost;
				end
				if (idx_q == (NODE_BITS+1)'(NODES))
					state_d = S_SCAN;
				else
					state_d = S_RELAX_RD;
			end
			S_OUT: begin
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// scan pipeline: cost read registered, compare in the following cycle
	logic                 scan_v_q;
	logic [NODE_BITS-1:0] scan_i_q;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR;
			clr_cnt_q    <= '0;
			present_q    <= '0;
			settled_q    <= '0;
			reached_q    <= '0;
			out_valid_q  <= 1'b0;
			idx_q        <= '0;
			phase_q      <= 1'b0;
			found_q      <= 1'b0;
			scan_v_q     <= 1'b0;
			cmd_q        <= '0;
		end else begin
			state_q  <= state_d;
			scan_v_q <= 1'b0;
			if (out_valid_q && m_axis_tready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_CLR: clr_cnt_q <= clr_cnt_q + 1'b1;
				S_IDLE: begin
					idx_q   <= '0;
					phase_q <= 1'b0;
					if (s_fire) begin
						cmd_q   <= s_axis_tdata[2:0];
						a_q     <= s_axis_tdata[7:3];
						b_q     <= s_axis_tdata[12:8];
						w_q     <= s_axis_tdata[20:13];
						tmode_q <= s_axis_tdata[21];
						if (s_axis_tdata[2:0] == CMD_ADD_VERTEX)
							present_q[s_axis_tdata[7:3]] <= 1'b1;
					end
				end
				S_EDGE_WR: begin
					if (cmd_q == CMD_DEL_VERTEX) begin
						if (phase_q) begin
							idx_q <= idx_q + 1'b1;
							if (idx_q == (NODE_BITS+1)'(NODES - 1))
								present_q[a_q] <= 1'b0;
						end
						phase_q <= !phase_q;
					end else if (!phase_q && state_d == S_EDGE_WR) begin
						phase_q <= 1'b1;
					end
				end
				S_INIT: begin
					settled_q    <= '0;
					reached_q    <= {{(NODES-1){1'b0}}, 1'b1} << a_q;
					idx_q        <= '0;
					found_q      <= 1'b0;
					res_cost_q   <= '0;
					res_status_q <= (!present_q[a_q] || !present_q[b_q]) ?
						ST_ABSENT : ST_UNREACH;
				end
				S_SCAN: begin
					if (idx_q != (NODE_BITS+1)'(NODES)) begin
						idx_q    <= idx_q + 1'b1;
						scan_v_q <= 1'b1;
						scan_i_q <= idx_lo;
					end
				end
				S_PICK: begin
					idx_q <= '0;
					if (found_q) begin
						settled_q[pick_q] <= 1'b1;
						if (pick_q == b_q) begin
							res_cost_q   <= pick_cost_q;
							res_status_q <= ST_OK;
						end
					end
				end
				S_RELAX_RD: begin
					nb_q  <= idx_lo;
					idx_q <= idx_q + 1'b1;
				end
				S_RELAX_WR: begin
					if (c_we)
						reached_q[nb_q] <= 1'b1;
					if (state_d == S_SCAN) begin
						idx_q   <= '0;
						found_q <= 1'b0;
					end
				end
				S_OUT: out_valid_q <= 1'b1;
				default: ;
			endcase
			// minimum search, lowest index wins ties
			if (scan_v_q && reached_q[scan_i_q] && !settled_q[scan_i_q] &&
				(!found_q || cost_rd_s1 < pick_cost_q)) begin
				found_q     <= 1'b1;
				pick_q      <= scan_i_q;
				pick_cost_q <= cost_rd_s1;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, res_status_q, res_cost_q};
endmodule
